// File: rtl/i2f_pkg.sv
// shared types, constants and float helpers for the int-to-float scaled converter
package i2f_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_GROUP = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

    localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
    localparam logic [31:0] EXP_MASK   = 32'h7F80_0000;
    localparam logic [31:0] SCALE_ONE  = 32'h3F80_0000;

    localparam logic [0:0] REG_MODE  = 1'b0;
    localparam logic [0:0] REG_SCALE = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic        do_mul;
        logic        sign;
        logic [31:0] conv;
        logic [31:0] scale;
        logic        last;
    } t_item;

    // multiply operands after unpacking, passed through the multiplier stage
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [9:0]  exp_sum;   // signed biased exponent ea+eb-126
        logic [23:0] ma;
        logic [23:0] mb;
        logic        last;
        logic        bypass;
        logic [31:0] bypass_val;
    } t_mulop;

    // position of highest set bit, 0 when none
    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) p = 5'(i);
        end
        return p;
    endfunction

    // signed 32-bit integer to binary32, round to nearest even
    function automatic logic [31:0] int_to_f32(input logic [31:0] raw);
        logic        s;
        logic [31:0] mag;
        logic [4:0]  p;
        logic [31:0] sh;
        logic [24:0] m;
        logic [31:0] rem;
        logic [31:0] half;
        logic [4:0]  sft;
        logic [31:0] res;
        s   = raw[31];
        mag = s ? (32'd0 - raw) : raw;
        p   = msb_pos(mag);
        res = 32'd0;
        if (mag != 32'd0) begin
            if (p <= 5'd23) begin
                sh = mag << (5'd23 - p);
                m  = sh[24:0];
            end else begin
                sft  = p - 5'd23;
                sh   = mag >> sft;
                m    = sh[24:0];
                rem  = mag & ((32'd1 << sft) - 32'd1);
                half = 32'd1 << (sft - 5'd1);
                // a rounding carry past the hidden bit lands in the exponent
                if (rem > half || (rem == half && m[0])) m = m + 25'd1;
            end
            res = {s, 31'd0} + (({27'd0, p} + 32'd126) << 23) + {7'd0, m};
        end
        return res;
    endfunction

endpackage

// File: rtl/i2f_front.sv
// front part: group tracking, scale selection and integer conversion
module i2f_front #(
    parameter int GROUP_SIZE = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_sample,
    input  logic [31:0]         i_group_scale_bits,
    input  logic                i_last_in,
    input  i2f_pkg::t_mode      i_mode,
    input  logic [31:0]         i_fixed_scale,
    output i2f_pkg::t_item      o_item
);
    localparam int PW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    logic [PW-1:0] r_pos, n_pos;
    logic [31:0]   r_held, n_held;
    logic [31:0]   w_conv;

    assign w_conv = i2f_pkg::int_to_f32(i_sample);

    always_comb begin
        n_pos  = r_pos;
        n_held = r_held;
        o_item.conv   = w_conv;
        o_item.sign   = 1'b0;
        o_item.last   = i_last_in;
        o_item.do_mul = 1'b0;
        o_item.scale  = i_fixed_scale;
        unique case (i_mode)
            i2f_pkg::MODE_FIXED: o_item.do_mul = 1'b1;
            i2f_pkg::MODE_GROUP: begin
                o_item.do_mul = 1'b1;
                if (r_pos == '0) n_held = i_group_scale_bits;
                o_item.scale = n_held;
            end
            default: o_item.do_mul = 1'b0;
        endcase
        if (i_valid) begin
            if (i_last_in || ({{(32-PW){1'b0}}, r_pos} + 32'd1 >= 32'(GROUP_SIZE)))
                n_pos = '0;
            else
                n_pos = r_pos + PW'(1);
        end else begin
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_held <= '0;
        end else begin
            r_pos  <= n_pos;
            r_held <= n_held;
        end
    end
endmodule

// File: rtl/i2f_back.sv
// back part: pipelined binary32 multiply with rounding, subnormals kept
module i2f_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  i2f_pkg::t_item      i_item,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_result,
    output logic                o_last
);
    // stage 1 unpack, stage 2 multiply, stage 3 round, then output register
    logic          r_v1, r_v2, r_v3;
    i2f_pkg::t_mulop r_op1, n_op1, r_op2;
    logic [47:0]   r_prod;
    logic [31:0]   r_res3, n_res3;
    logic          r_last3;
    logic          w_adv;

    assign w_adv   = !r_v3 || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v3;
    assign o_result = r_res3;
    assign o_last   = r_last3;

    function automatic void unpack_f(input logic [30:0] x,
                                     output logic [9:0] e, output logic [23:0] m);
        logic [4:0] p;
        if (x[30:23] == 8'd0) begin
            p = i2f_pkg::msb_pos({9'd0, x[22:0]});
            m = 24'(x[22:0]) << (5'd23 - p);
            e = 10'(p) - 10'd22;
        end else begin
            e = {2'd0, x[30:23]};
            m = {1'b1, x[22:0]};
        end
    endfunction

    always_comb begin
        logic [30:0] aa, bb;
        logic [9:0]  ea, eb;
        logic [23:0] ma, mb;
        aa = i_item.conv[30:0];
        bb = i_item.scale[30:0];
        unpack_f(aa, ea, ma);
        unpack_f(bb, eb, mb);
        n_op1.sign        = i_item.conv[31] ^ i_item.scale[31];
        n_op1.exp_sum     = ea + eb - 10'd126;
        n_op1.ma          = ma;
        n_op1.mb          = mb;
        n_op1.last        = i_item.last;
        n_op1.bypass      = !i_item.do_mul;
        n_op1.bypass_val  = i_item.conv;
        n_op1.special     = 1'b1;
        n_op1.special_val = {n_op1.sign, 31'd0};
        if ({1'b0, aa} > i2f_pkg::EXP_MASK || {1'b0, bb} > i2f_pkg::EXP_MASK)
            n_op1.special_val = i2f_pkg::CANON_NAN;
        else if ({1'b0, aa} == i2f_pkg::EXP_MASK || {1'b0, bb} == i2f_pkg::EXP_MASK)
            n_op1.special_val = (aa == '0 || bb == '0) ? i2f_pkg::CANON_NAN
                                : {n_op1.sign, i2f_pkg::EXP_MASK[30:0]};
        else if (aa == '0 || bb == '0)
            n_op1.special_val = {n_op1.sign, 31'd0};
        else
            n_op1.special = 1'b0;
    end

    always_comb begin
        logic [50:0] p;
        logic signed [9:0] e;
        logic [5:0]  sft;
        logic [50:0] m, rem, half;
        logic [31:0] res;
        p   = {3'd0, r_prod};
        e   = $signed(r_op2.exp_sum);
        if (!p[47]) begin
            p = p << 1;
            e = e - 10'sd1;
        end
        // deep underflow shifts everything into the sticky remainder
        if (e >= 10'sd1) sft = 6'd24;
        else if ((10'sd1 - e) > 10'sd26) sft = 6'd50;
        else sft = 6'(10'sd24 + 10'sd1 - e);
        m    = p >> sft;
        rem  = p & ((51'd1 << sft) - 51'd1);
        half = 51'd1 << (sft - 6'd1);
        if (rem > half || (rem == half && m[0])) m = m + 51'd1;
        if (e < 10'sd1)
            res = {r_op2.sign, 31'(m)};
        else if (e >= 10'sd255)
            res = {r_op2.sign, i2f_pkg::EXP_MASK[30:0]};
        else begin
            res = ({22'd0, e} - 32'd1 << 23) + 32'(m);
            if (res >= i2f_pkg::EXP_MASK) res = i2f_pkg::EXP_MASK;
            res = {r_op2.sign, res[30:0]};
        end
        if (r_op2.bypass) n_res3 = r_op2.bypass_val;
        else if (r_op2.special) n_res3 = r_op2.special_val;
        else n_res3 = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1   <= n_op1;
            r_op2   <= r_op1;
            r_prod  <= r_op1.ma * r_op1.mb;
            r_res3  <= n_res3;
            r_last3 <= r_op2.last;
        end
    end
endmodule

// File: rtl/i2f_fifo.sv
// short queue between the front and back parts, also used as the result queue
module i2f_fifo #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + AW'(1);
            if (w_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end
endmodule

// File: rtl/int32_to_fp32_scaled_converter.sv
// top level: int32 to binary32 converter with fixed or per-group scaling
//  channel  | handshake         | beat
//  input    | i_push / o_full   | i_sample, i_group_scale_bits, i_last_in
//  result   | o_empty / i_pop   | o_result_bits, o_last_out
//  config   | apb write/read    | conversion_mode @0, fixed_scale_bits @4
// one item per cycle while o_full is low; a result passes the input queue, then the
// unpack, multiply and round stages, then the result queue before the ports.
// synchronous active-low reset clears queues, group position and valid bits, presets config.
// a stalled result queue fills and raises o_full; front and back stall apart.
module int32_to_fp32_scaled_converter #(
    parameter int GROUP_SIZE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_sample,
    input  logic [31:0] i_group_scale_bits,
    input  logic        i_last_in,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_result_bits,
    output logic        o_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    i2f_pkg::t_mode r_mode;
    logic [31:0]    r_scale;
    logic           w_acc;
    i2f_pkg::t_item w_item, w_qitem;
    logic           w_qempty, w_bready, w_bvalid;
    logic [31:0]    w_bres;
    logic           w_blast, w_ofull;

    assign pready = 1'b1;
    assign w_acc  = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= i2f_pkg::MODE_PLAIN;
            r_scale <= i2f_pkg::SCALE_ONE;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == i2f_pkg::REG_MODE) r_mode <= i2f_pkg::t_mode'(pwdata[1:0]);
            else                               r_scale <= pwdata;
        end
    end

    always_comb begin
        if (paddr[2] == i2f_pkg::REG_MODE) prdata = {30'd0, r_mode};
        else                               prdata = r_scale;
    end

    i2f_front #(.GROUP_SIZE(GROUP_SIZE)) u_front (
        .i_clk, .i_rst_n, .i_valid(w_acc), .i_sample, .i_group_scale_bits,
        .i_last_in, .i_mode(r_mode), .i_fixed_scale(r_scale), .o_item(w_item)
    );

    i2f_fifo #(.WIDTH($bits(i2f_pkg::t_item)), .DEPTH(4)) u_q (
        .i_clk, .i_rst_n, .i_push(i_push), .i_data(w_item), .o_full(o_full),
        .i_pop(w_bready), .o_empty(w_qempty), .o_data(w_qitem)
    );

    i2f_back u_back (
        .i_clk, .i_rst_n, .i_valid(!w_qempty), .i_item(w_qitem), .o_ready(w_bready),
        .o_valid(w_bvalid), .i_ready(!w_ofull), .o_result(w_bres), .o_last(w_blast)
    );

    // result queue deep enough that the back part rarely stalls
    i2f_fifo #(.WIDTH(33), .DEPTH(4)) u_oq (
        .i_clk, .i_rst_n, .i_push(w_bvalid), .i_data({w_blast, w_bres}),
        .o_full(w_ofull), .i_pop(i_pop), .o_empty(o_empty),
        .o_data({o_last_out, o_result_bits})
    );
endmodule

// File: rtl/i2f_checker.sv
// port-level checker bound to the converter top level
module i2f_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [31:0] o_result_bits,
    input logic        pready
);
    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("results after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("full after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> $stable(o_result_bits))
        else $error("waiting result changed");
endmodule

bind int32_to_fp32_scaled_converter i2f_checker u_chk (
    .i_clk, .i_rst_n, .i_push, .o_full, .o_empty, .i_pop, .o_result_bits, .pready
);
